// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  // Fixed field widths of the stream payload
  localparam int REQ_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = 12;
  localparam int OCC_OUT_W   = 11;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 112;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ_INDEX = 3'd4,
    REQ_CLEAR      = 3'd5,
    REQ_FILL       = 3'd6,
    REQ_RESIZE     = 3'd7
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_PUSH_FULL   = 3'd1,
    ST_POP_EMPTY   = 3'd2,
    ST_INDEX_RANGE = 3'd3,
    ST_COUNT_CLIP  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_FRONT,
    S_RD_BACK,
    S_RD_INDEX,
    S_DONE
  } state_t;

endpackage

// ===== design/deq_ring_mem.sv =====
`timescale 1ns / 1ps

// Ring storage: one write port, one read port, registered read data
module deq_ring_mem #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32,
  parameter int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/circular_double_ended_queue.sv =====
// Sequence: the request is taken in S_IDLE; S_RD_FRONT, S_RD_BACK and S_RD_INDEX then read
//   the ring and S_DONE loads the result. Fill and resize first write one ring entry per
//   S_FILL step (up to DEPTH). Requests are handled one at a time, set by the single ring
//   read port reading front, back and indexed entry in turn; S_DONE stalls on out_tready.
// Reset (rst_n low, synchronous): head position and occupancy cleared, no result pending;
//   ring contents are not cleared.
`timescale 1ns / 1ps

module circular_double_ended_queue #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: value[31:0], count[43:32], index[55:44]
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [deq_pkg::REQ_W-1:0]         in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: index_value[31:0], front_value[63:32], back_value[95:64],
  //            occupancy[106:96], is_empty[107], zero pad[111:108]
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: status[2:0]
  output logic [deq_pkg::STATUS_W-1:0]      out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = deq_pkg::CNT_W + 1;

  localparam logic [ADDR_W:0]   DEPTH_S   = (ADDR_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0]  DEPTH_OCC = OCC_W'(DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(DEPTH);
  localparam int PAD_W = deq_pkg::OUT_TDATA_W - 3 * deq_pkg::VALUE_W - deq_pkg::OCC_OUT_W - 1;

  // Ring slot arithmetic modulo DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[ADDR_W-1:0];
  endfunction

  // Input field split
  logic [deq_pkg::VALUE_W-1:0] in_value;
  logic [deq_pkg::CNT_W-1:0]   in_count;
  logic [deq_pkg::CNT_W-1:0]   in_index;
  deq_pkg::req_t               in_req;

  assign in_value = in_tdata[31:0];
  assign in_count = in_tdata[43:32];
  assign in_index = in_tdata[55:44];
  assign in_req   = deq_pkg::req_t'(in_tuser);

  // State
  deq_pkg::state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]           head_r, head_nxt;
  logic [OCC_W-1:0]            occ_r, occ_nxt;
  deq_pkg::req_t               req_r, req_nxt;
  deq_pkg::status_t            status_r, status_nxt;
  logic [WORD_BITS-1:0]        val_r, val_nxt;
  logic [ADDR_W-1:0]           fill_slot_r, fill_slot_nxt;
  logic [OCC_W-1:0]            fill_left_r, fill_left_nxt;
  logic [ADDR_W-1:0]           idx_slot_r, idx_slot_nxt;
  logic                        idx_ok_r, idx_ok_nxt;
  logic [WORD_BITS-1:0]        front_r, front_nxt;
  logic [WORD_BITS-1:0]        back_r, back_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [deq_pkg::STATUS_W-1:0]    out_tuser_r, out_tuser_nxt;

  // Memory port signals
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  deq_ring_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .ADDR_W    (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode helpers for the incoming request
  logic [WORD_BITS-1:0] in_word;
  logic                 is_full;
  logic                 is_emp;
  logic                 cnt_clip;
  logic [OCC_W-1:0]     n_val;
  logic [OCC_W-1:0]     keep_val;
  logic [ADDR_W-1:0]    head_dec;
  logic [ADDR_W-1:0]    head_inc;
  logic                 out_free;
  logic                 emp_now;
  logic [31:0]          front32, back32, index32;

  assign in_word  = WORD_BITS'(in_value);
  assign is_full  = (occ_r == DEPTH_OCC);
  assign is_emp   = (occ_r == '0);
  assign cnt_clip = ({1'b0, in_count} > DEPTH_CMP);
  assign n_val    = cnt_clip ? DEPTH_OCC : OCC_W'(in_count);
  assign keep_val = (n_val < occ_r) ? n_val : occ_r;
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc = wrap_add(head_r, ADDR_W'(1));
  assign out_free = !out_tvalid_r || out_tready;
  assign emp_now  = (occ_r == '0);
  assign front32  = emp_now ? 32'd0 : 32'(front_r);
  assign back32   = emp_now ? 32'd0 : 32'(back_r);
  assign index32  = (req_r == deq_pkg::REQ_READ_INDEX && idx_ok_r) ? 32'(rd_data) : 32'd0;

  // Sequencer: next state, ring accesses, result assembly
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    val_nxt        = val_r;
    fill_slot_nxt  = fill_slot_r;
    fill_left_nxt  = fill_left_r;
    idx_slot_nxt   = idx_slot_r;
    idx_ok_nxt     = idx_ok_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    wr_en          = 1'b0;
    wr_addr        = fill_slot_r;
    wr_data        = val_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    in_tready      = (state_r == deq_pkg::S_IDLE);

    case (state_r)
      deq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt       = in_req;
          val_nxt       = in_word;
          status_nxt    = deq_pkg::ST_OK;
          idx_ok_nxt    = 1'b0;
          idx_slot_nxt  = wrap_add(head_r, ADDR_W'(in_index));
          fill_left_nxt = '0;
          state_nxt     = deq_pkg::S_RD_FRONT;
          case (in_req)
            deq_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = deq_pkg::ST_PUSH_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_r, ADDR_W'(occ_r));
                wr_data = in_word;
                occ_nxt = occ_r + 1'b1;
              end
            end
            deq_pkg::REQ_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = deq_pkg::ST_PUSH_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = head_dec;
                wr_data  = in_word;
                head_nxt = head_dec;
                occ_nxt  = occ_r + 1'b1;
              end
            end
            deq_pkg::REQ_POP_BACK: begin
              if (is_emp) begin
                status_nxt = deq_pkg::ST_POP_EMPTY;
              end else begin
                occ_nxt = occ_r - 1'b1;
              end
            end
            deq_pkg::REQ_POP_FRONT: begin
              if (is_emp) begin
                status_nxt = deq_pkg::ST_POP_EMPTY;
              end else begin
                head_nxt = head_inc;
                occ_nxt  = occ_r - 1'b1;
              end
            end
            deq_pkg::REQ_READ_INDEX: begin
              if ({1'b0, in_index} >= CMP_W'(occ_r)) begin
                status_nxt = deq_pkg::ST_INDEX_RANGE;
              end else begin
                idx_ok_nxt = 1'b1;
              end
            end
            deq_pkg::REQ_CLEAR: begin
              head_nxt = '0;
              occ_nxt  = '0;
            end
            deq_pkg::REQ_FILL: begin
              if (cnt_clip) begin
                status_nxt = deq_pkg::ST_COUNT_CLIP;
              end
              head_nxt      = '0;
              occ_nxt       = n_val;
              fill_slot_nxt = '0;
              fill_left_nxt = n_val;
              if (n_val != '0) begin
                state_nxt = deq_pkg::S_FILL;
              end
            end
            deq_pkg::REQ_RESIZE: begin
              if (cnt_clip) begin
                status_nxt = deq_pkg::ST_COUNT_CLIP;
              end
              occ_nxt       = n_val;
              fill_slot_nxt = wrap_add(head_r, ADDR_W'(keep_val));
              fill_left_nxt = n_val - keep_val;
              if (n_val != keep_val) begin
                state_nxt = deq_pkg::S_FILL;
              end
            end
            default: begin
              state_nxt = deq_pkg::S_RD_FRONT;
            end
          endcase
        end
      end

      // Write sweep for fill and resize, one entry a cycle
      deq_pkg::S_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = fill_slot_r;
        wr_data       = val_r;
        fill_slot_nxt = wrap_add(fill_slot_r, ADDR_W'(1));
        fill_left_nxt = fill_left_r - 1'b1;
        if (fill_left_r == OCC_W'(1)) begin
          state_nxt = deq_pkg::S_RD_FRONT;
        end
      end

      deq_pkg::S_RD_FRONT: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = deq_pkg::S_RD_BACK;
      end

      deq_pkg::S_RD_BACK: begin
        front_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = wrap_add(head_r, ADDR_W'(occ_r - 1'b1));
        state_nxt = deq_pkg::S_RD_INDEX;
      end

      deq_pkg::S_RD_INDEX: begin
        back_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = idx_slot_r;
        state_nxt = deq_pkg::S_DONE;
      end

      // Indexed word sits on rd_data; wait for the output register
      deq_pkg::S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD_W{1'b0}}, emp_now, deq_pkg::OCC_OUT_W'(occ_r),
                            back32, front32, index32};
          out_tuser_nxt  = status_r;
          state_nxt      = deq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= deq_pkg::S_IDLE;
      head_r       <= '0;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      occ_r        <= occ_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    status_r    <= status_nxt;
    val_r       <= val_nxt;
    fill_slot_r <= fill_slot_nxt;
    fill_left_r <= fill_left_nxt;
    idx_slot_r  <= idx_slot_nxt;
    idx_ok_r    <= idx_ok_nxt;
    front_r     <= front_nxt;
    back_r      <= back_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
